// ===== design/ac_ir_frame_encoder_assert.svh =====
// assertion macros for the ir frame encoder
`ifndef AC_IR_FRAME_ENCODER_ASSERT_SVH
`define AC_IR_FRAME_ENCODER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define ACIR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acir implication check failed");
// next-cycle implication, sampled on clk, off during reset
`define ACIR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acir next-cycle check failed");
`else
`define ACIR_ASSERT_IMP(lbl, ante, cons)
`define ACIR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/acir_pkg.sv =====
// shared types, constants and helper functions for the ir frame encoder
`default_nettype none
package acir_pkg;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	// command codes
	localparam logic [3:0] CMD_STATE     = 4'd0;
	localparam logic [3:0] CMD_POWER_OFF = 4'd1;
	localparam logic [3:0] CMD_SWING     = 4'd2;
	localparam logic [3:0] CMD_TURBO     = 4'd3;
	localparam logic [3:0] CMD_LIGHT     = 4'd4;
	localparam logic [3:0] CMD_ECONO     = 4'd5;
	localparam logic [3:0] CMD_QUIET_ON  = 4'd6;
	localparam logic [3:0] CMD_QUIET_OFF = 4'd7;
	localparam logic [3:0] CMD_CLEAN     = 4'd8;
	localparam logic [3:0] CMD_HEAT8     = 4'd9;

	// mode input codes
	localparam logic [2:0] MODE_OFF  = 3'd0;
	localparam logic [2:0] MODE_COOL = 3'd1;
	localparam logic [2:0] MODE_AUTO = 3'd2;
	localparam logic [2:0] MODE_DRY  = 3'd3;
	localparam logic [2:0] MODE_HEAT = 3'd4;
	localparam logic [2:0] MODE_FAN  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_ALT_SWING    = 2'd0;
	localparam logic [1:0] CFG_TEMP_FLOOR   = 2'd1;
	localparam logic [1:0] CFG_TEMP_CEILING = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		STAT_PAIR   = 2'd0,
		STAT_ACCEPT = 2'd1,
		STAT_REJECT = 2'd2,
		STAT_IDLE   = 2'd3
	} status_t;

	// pulse timings in microseconds
	localparam logic [12:0] HDR_US        = 13'd4480;
	localparam logic [12:0] BIT_MARK_US   = 13'd560;
	localparam logic [12:0] ONE_SPACE_US  = 13'd1680;
	localparam logic [12:0] ZERO_SPACE_US = 13'd560;
	localparam logic [12:0] GAP_US        = 13'd5600;

	// pair positions within one transmission
	localparam logic [6:0] POS_HDR_A = 7'd0;
	localparam logic [6:0] POS_GAP   = 7'd49;
	localparam logic [6:0] POS_HDR_B = 7'd50;
	localparam logic [6:0] POS_FINAL = 7'd99;
	localparam logic [6:0] BIT_TOP_A = 7'd48;
	localparam logic [6:0] BIT_TOP_B = 7'd98;

	// frame header byte: 0b10100 header and 0b001 type
	localparam logic [7:0] TYPE_BYTE = {5'b10100, 3'b001};

	// fixed feature words
	localparam logic [47:0] WORD_SWING     = 48'hA201FFFFFF7C;
	localparam logic [47:0] WORD_ECONO     = 48'hA202FFFFFF7E;
	localparam logic [47:0] WORD_LIGHT     = 48'hA208FFFFFF75;
	localparam logic [47:0] WORD_TURBO     = 48'hA209FFFFFF74;
	localparam logic [47:0] WORD_CLEAN     = 48'hA20DFFFFFF70;
	localparam logic [47:0] WORD_HEAT8     = 48'hA20FFFFFFF73;
	localparam logic [47:0] WORD_QUIET_ON  = 48'hA212FFFFFF6E;
	localparam logic [47:0] WORD_QUIET_OFF = 48'hA213FFFFFF6F;

	// configuration register set
	typedef struct packed {
		logic       alt_swing_model;
		logic [7:0] temp_floor;
		logic [7:0] temp_ceiling;
	} cfg_t;

	// packer result
	typedef struct packed {
		logic        ok;
		logic [47:0] word;
	} pack_res_t;

	// reverse bit order of a byte
	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

	// mode input to packed mode code, off and invalid pack as cool
	function automatic logic [2:0] mode_code(input logic [2:0] m);
		logic [2:0] c;
		unique case (m)
			MODE_AUTO: c = 3'd2;
			MODE_DRY:  c = 3'd1;
			MODE_HEAT: c = 3'd3;
			MODE_FAN:  c = 3'd4;
			default:   c = 3'd0;
		endcase
		return c;
	endfunction

	// checksum over bytes 1..5: sum of reversed bytes, negated, reversed
	function automatic logic [7:0] check_byte(input logic [47:0] w);
		logic [7:0] sum;
		sum = flip8(w[15:8]) + flip8(w[23:16]) + flip8(w[31:24])
			+ flip8(w[39:32]) + flip8(w[47:40]);
		return flip8(8'd0 - sum);
	endfunction

endpackage
`default_nettype wire

// ===== design/ac_ir_frame_encoder.sv =====
// An accepted item waits in the input register, and its result goes to the result
// register when stage 1 advances. One item per cycle while out_ready drains results;
// the frame state is updated as the input register hands its item on.
// Reset (arst_n low, asynchronous): idle, no frame, limits 17..30, swing model 0.
// Configuration writes are taken in any cycle.
`default_nettype none
`include "ac_ir_frame_encoder_assert.svh"
module ac_ir_frame_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// input item channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [3:0]  command,
	input  wire logic [2:0]  mode,
	input  wire logic [2:0]  fan,
	input  wire logic [7:0]  temperature,
	// result item channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [12:0]      mark_us,
	output logic [12:0]      space_us,
	output logic             last,
	output logic [1:0]       status
);

	acir_pkg::cfg_t      cfg_q;
	acir_pkg::pack_res_t pack;

	logic        valid_s1;
	logic        op_s1;
	logic [3:0]  cmd_s1;
	logic [2:0]  mode_s1;
	logic [2:0]  fan_s1;
	logic [7:0]  temp_s1;

	logic [47:0] frame_q;
	logic [6:0]  pos_q;
	logic        sending_q;

	logic        out_valid_q;
	logic [12:0] mark_q;
	logic [12:0] space_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        adv;
	logic [47:0] frame_nxt;
	logic [6:0]  pos_nxt;
	logic        sending_nxt;
	logic [12:0] mark_nxt;
	logic [12:0] space_nxt;
	logic        last_nxt;
	logic [1:0]  status_nxt;
	logic [6:0]  bit_off;
	logic [5:0]  bit_idx;
	logic        second_half;
	logic        tx_bit;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alt_swing_model <= 1'b0;
			cfg_q.temp_floor      <= 8'd17;
			cfg_q.temp_ceiling    <= 8'd30;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				acir_pkg::CFG_ALT_SWING:    cfg_q.alt_swing_model <= cfg_data[0];
				acir_pkg::CFG_TEMP_FLOOR:   cfg_q.temp_floor      <= cfg_data;
				acir_pkg::CFG_TEMP_CEILING: cfg_q.temp_ceiling    <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			cmd_s1  <= command;
			mode_s1 <= mode;
			fan_s1  <= fan;
			temp_s1 <= temperature;
		end
	end

	// frame packer
	acir_frame_pack u_pack (
		.command     (cmd_s1),
		.mode        (mode_s1),
		.fan         (fan_s1),
		.temperature (temp_s1),
		.cfg         (cfg_q),
		.res         (pack)
	);

	// data bit selection: first copy as is, second copy inverted
	always_comb begin
		second_half = (pos_q > acir_pkg::POS_HDR_B);
		bit_off     = second_half ? (acir_pkg::BIT_TOP_B - pos_q) : (acir_pkg::BIT_TOP_A - pos_q);
		bit_idx     = bit_off[5:0];
		tx_bit      = frame_q[bit_idx] ^ second_half;
	end

	// result and next state for the item in stage 1
	always_comb begin
		frame_nxt   = frame_q;
		pos_nxt     = pos_q;
		sending_nxt = sending_q;
		mark_nxt    = '0;
		space_nxt   = '0;
		last_nxt    = 1'b0;
		status_nxt  = acir_pkg::STAT_PAIR;
		if (op_s1 == acir_pkg::OP_START) begin
			if (pack.ok) begin
				frame_nxt   = pack.word;
				pos_nxt     = '0;
				sending_nxt = 1'b1;
				status_nxt  = acir_pkg::STAT_ACCEPT;
			end else begin
				status_nxt  = acir_pkg::STAT_REJECT;
			end
		end else if (!sending_q) begin
			status_nxt = acir_pkg::STAT_IDLE;
		end else begin
			pos_nxt = pos_q + 7'd1;
			priority if (pos_q == acir_pkg::POS_HDR_A || pos_q == acir_pkg::POS_HDR_B) begin
				mark_nxt  = acir_pkg::HDR_US;
				space_nxt = acir_pkg::HDR_US;
			end else if (pos_q == acir_pkg::POS_GAP) begin
				mark_nxt  = acir_pkg::BIT_MARK_US;
				space_nxt = acir_pkg::GAP_US;
			end else if (pos_q >= acir_pkg::POS_FINAL) begin
				mark_nxt    = acir_pkg::BIT_MARK_US;
				last_nxt    = 1'b1;
				sending_nxt = 1'b0;
				pos_nxt     = '0;
			end else begin
				mark_nxt  = acir_pkg::BIT_MARK_US;
				space_nxt = tx_bit ? acir_pkg::ONE_SPACE_US : acir_pkg::ZERO_SPACE_US;
			end
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			pos_q     <= '0;
			sending_q <= 1'b0;
		end else if (adv) begin
			frame_q   <= frame_nxt;
			pos_q     <= pos_nxt;
			sending_q <= sending_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mark_q   <= mark_nxt;
			space_q  <= space_nxt;
			last_q   <= last_nxt;
			status_q <= status_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign mark_us   = mark_q;
	assign space_us  = space_q;
	assign last      = last_q;
	assign status    = status_q;

	// checks
	`ACIR_ASSERT_IMP(a_idle_pos_zero, !sending_q, pos_q == 7'd0)
	`ACIR_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= acir_pkg::POS_FINAL)
	`ACIR_ASSERT_IMP(a_last_is_pair, out_valid_q && last_q, status_q == acir_pkg::STAT_PAIR)
	`ACIR_ASSERT_NXT(a_final_goes_idle, adv && last_nxt, !sending_q && out_valid_q && last_q)

endmodule
`default_nettype wire

// ===== design/acir_frame_pack.sv =====
// builds the 48-bit frame word for a start command
`default_nettype none
module acir_frame_pack (
	input  wire logic [3:0]       command,
	input  wire logic [2:0]       mode,
	input  wire logic [2:0]       fan,
	input  wire logic [7:0]       temperature,
	input  wire acir_pkg::cfg_t   cfg,
	output acir_pkg::pack_res_t   res
);

	logic [7:0]  t_lo;
	logic [7:0]  t_cl;
	logic [7:0]  t_off;
	logic [1:0]  fan_code;
	logic        mode_ok;
	logic [7:0]  b4;
	logic [47:0] body;
	logic [47:0] state_word;

	// clamp temperature: raise to floor first, then lower to ceiling
	always_comb begin
		t_lo  = (temperature < cfg.temp_floor) ? cfg.temp_floor : temperature;
		t_cl  = (t_lo > cfg.temp_ceiling) ? cfg.temp_ceiling : t_lo;
		t_off = t_cl - cfg.temp_floor;
	end

	// mode and fan validity
	assign mode_ok  = (mode != acir_pkg::MODE_OFF) && (mode <= acir_pkg::MODE_FAN);
	assign fan_code = (fan <= 3'd3) ? fan[1:0] : 2'd0;

	// state frame body and checksum; power bit set only for the state command
	always_comb begin
		b4 = {(command == acir_pkg::CMD_STATE), 2'b00, fan_code, acir_pkg::mode_code(mode)};
		body = {acir_pkg::TYPE_BYTE, b4, 3'b000, t_off[4:0], 8'hFF, 8'hFF, 8'h00};
		state_word = {body[47:8], acir_pkg::check_byte(body)};
	end

	// command select
	always_comb begin
		res.ok   = 1'b1;
		res.word = '0;
		unique case (command)
			acir_pkg::CMD_STATE: begin
				res.ok   = mode_ok;
				res.word = state_word;
			end
			acir_pkg::CMD_POWER_OFF: res.word = state_word;
			acir_pkg::CMD_SWING: begin
				res.word = cfg.alt_swing_model ? acir_pkg::WORD_ECONO : acir_pkg::WORD_SWING;
			end
			acir_pkg::CMD_TURBO:     res.word = acir_pkg::WORD_TURBO;
			acir_pkg::CMD_LIGHT:     res.word = acir_pkg::WORD_LIGHT;
			acir_pkg::CMD_ECONO:     res.word = acir_pkg::WORD_ECONO;
			acir_pkg::CMD_QUIET_ON:  res.word = acir_pkg::WORD_QUIET_ON;
			acir_pkg::CMD_QUIET_OFF: res.word = acir_pkg::WORD_QUIET_OFF;
			acir_pkg::CMD_CLEAN:     res.word = acir_pkg::WORD_CLEAN;
			acir_pkg::CMD_HEAT8:     res.word = acir_pkg::WORD_HEAT8;
			default:                 res.ok   = 1'b0;
		endcase
	end

endmodule
`default_nettype wire
